// ----- rtl/ccirc_pkg.sv -----
// ----------------------------------------------------------------------------
// ccirc_pkg
// Widths and stage records shared by the circumcircle datapath.
// ----------------------------------------------------------------------------
package ccirc_pkg;

    localparam int CW   = 16;             // coordinate bits
    localparam int FRAC = 8;              // fraction bits of results
    localparam int DW   = CW + 1;         // coordinate difference
    localparam int PW   = 2 * DW;         // cross product term
    localparam int DWD  = PW + 2;         // twice the cross product (four times the signed area)
    localparam int SAW  = 2 * DW;         // squared edge length
    localparam int NXW  = SAW + DW + 1;   // centre numerator offset
    localparam int NUMW = NXW + 1;        // numerator before scaling
    localparam int NW   = NUMW + FRAC;    // scaled numerator
    localparam int DMW  = DWD;            // divisor magnitude
    localparam int QW   = 32;             // result width
    localparam int DSW  = DMW + QW - 1;   // shifted divisor
    localparam int HW   = NXW / 2;        // split for partial products
    localparam int RW   = 2 * NXW + 2 * FRAC;
    localparam int SQW  = RW / 2;         // square root width
    localparam int RRW  = SQW + 3;        // square root remainder

    typedef struct packed {
        logic [NW-1:0]  mag_x;
        logic [NW-1:0]  mag_y;
        logic           neg_x;
        logic           neg_y;
        logic [DMW-1:0] dmag;
        logic           deg;
    } t_ctx;

    typedef struct packed {
        logic [RW-1:0]  rad;
        logic [RRW-1:0] rem;
        logic [SQW-1:0] root;
        t_ctx           ctx;
    } t_sq;

    typedef struct packed {
        logic [NW-1:0]  rem_x;
        logic [NW-1:0]  rem_y;
        logic [NW-1:0]  rem_r;
        logic [QW-1:0]  q_x;
        logic [QW-1:0]  q_y;
        logic [QW-1:0]  q_r;
        logic [DSW-1:0] dsh;
        logic           neg_x;
        logic           neg_y;
        logic           ov_x;
        logic           ov_y;
        logic           ov_r;
        logic           deg;
    } t_dv;

endpackage

// ----- rtl/ccirc_front.sv -----
// ----------------------------------------------------------------------------
// ccirc_front
// Products, numerators and radicand ahead of the square root cells.
// ----------------------------------------------------------------------------
module ccirc_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [6*ccirc_pkg::CW-1:0] i_data,
    output logic                    o_valid,
    output ccirc_pkg::t_sq          o_data
);
    import ccirc_pkg::*;

    logic [5:0] r_vld;

    // stage 1: differences
    logic signed [DW-1:0] r1_ax, r1_ay, r1_bx, r1_by;
    logic signed [CW-1:0] r1_x1, r1_y1;
    // stage 2: products
    logic signed [DWD-1:0] r2_d;
    logic [SAW-1:0]        r2_sa, r2_sb;
    logic signed [DW-1:0]  r2_ax, r2_ay, r2_bx, r2_by;
    logic signed [CW-1:0]  r2_x1, r2_y1;
    // stage 3: numerators
    logic signed [NXW-1:0]  r3_nx, r3_ny;
    logic signed [NUMW-1:0] r3_mx, r3_my;
    logic signed [DWD-1:0]  r3_d;
    // stage 4: magnitudes
    t_ctx           r4_ctx;
    logic [NXW-1:0] r4_anx, r4_any;
    // stage 5: partial products
    t_ctx             r5_ctx;
    logic [2*HW-1:0]  r5_hhx, r5_hlx, r5_llx, r5_hhy, r5_hly, r5_lly;
    // stage 6: radicand
    t_ctx          r6_ctx;
    logic [RW-1:0] r6_rad;

    logic signed [DW-1:0]   n_ax, n_ay, n_bx, n_by;
    logic signed [CW-1:0]   w_x1, w_y1;
    logic signed [PW-1:0]   w_p, w_q;
    logic signed [NXW-1:0]  w_sa, w_sb, w_nx, w_ny;
    logic signed [NW-1:0]   w_numx, w_numy;
    logic [RW-1:0]          w_sqx, w_sqy;

    always_comb begin
        w_x1 = i_data[CW-1:0];
        w_y1 = i_data[2*CW-1:CW];
        n_ax = DW'($signed(i_data[3*CW-1:2*CW])) - DW'(w_x1);
        n_ay = DW'($signed(i_data[4*CW-1:3*CW])) - DW'(w_y1);
        n_bx = DW'($signed(i_data[5*CW-1:4*CW])) - DW'(w_x1);
        n_by = DW'($signed(i_data[6*CW-1:5*CW])) - DW'(w_y1);
        w_p  = PW'(r1_ax) * PW'(r1_by);
        w_q  = PW'(r1_ay) * PW'(r1_bx);
        w_sa = NXW'($signed({1'b0, r2_sa}));
        w_sb = NXW'($signed({1'b0, r2_sb}));
        w_nx = w_sa * NXW'(r2_by) - w_sb * NXW'(r2_ay);
        w_ny = w_sb * NXW'(r2_ax) - w_sa * NXW'(r2_bx);
        w_numx = (NW'(r3_mx) + NW'(r3_nx)) <<< FRAC;
        w_numy = (NW'(r3_my) + NW'(r3_ny)) <<< FRAC;
        w_sqx = (RW'(r5_hhx) << (2 * HW)) + (RW'(r5_hlx) << (HW + 1)) + RW'(r5_llx);
        w_sqy = (RW'(r5_hhy) << (2 * HW)) + (RW'(r5_hly) << (HW + 1)) + RW'(r5_lly);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ax <= n_ax;
            r1_ay <= n_ay;
            r1_bx <= n_bx;
            r1_by <= n_by;
            r1_x1 <= w_x1;
            r1_y1 <= w_y1;

            r2_d  <= (DWD'(w_p) - DWD'(w_q)) <<< 1;
            r2_sa <= SAW'(PW'(r1_ax) * PW'(r1_ax)) + SAW'(PW'(r1_ay) * PW'(r1_ay));
            r2_sb <= SAW'(PW'(r1_bx) * PW'(r1_bx)) + SAW'(PW'(r1_by) * PW'(r1_by));
            r2_ax <= r1_ax;
            r2_ay <= r1_ay;
            r2_bx <= r1_bx;
            r2_by <= r1_by;
            r2_x1 <= r1_x1;
            r2_y1 <= r1_y1;

            r3_nx <= w_nx;
            r3_ny <= w_ny;
            r3_mx <= NUMW'(r2_x1) * NUMW'(r2_d);
            r3_my <= NUMW'(r2_y1) * NUMW'(r2_d);
            r3_d  <= r2_d;

            r4_ctx.neg_x <= w_numx[NW-1] ^ r3_d[DWD-1];
            r4_ctx.neg_y <= w_numy[NW-1] ^ r3_d[DWD-1];
            r4_ctx.mag_x <= w_numx[NW-1] ? NW'(-w_numx) : NW'(w_numx);
            r4_ctx.mag_y <= w_numy[NW-1] ? NW'(-w_numy) : NW'(w_numy);
            r4_ctx.dmag  <= r3_d[DWD-1] ? DMW'(-r3_d) : DMW'(r3_d);
            r4_ctx.deg   <= (r3_d == '0);
            r4_anx <= r3_nx[NXW-1] ? NXW'(-r3_nx) : NXW'(r3_nx);
            r4_any <= r3_ny[NXW-1] ? NXW'(-r3_ny) : NXW'(r3_ny);

            r5_ctx <= r4_ctx;
            r5_hhx <= (2*HW)'(r4_anx[NXW-1:HW]) * (2*HW)'(r4_anx[NXW-1:HW]);
            r5_hlx <= (2*HW)'(r4_anx[NXW-1:HW]) * (2*HW)'(r4_anx[HW-1:0]);
            r5_llx <= (2*HW)'(r4_anx[HW-1:0]) * (2*HW)'(r4_anx[HW-1:0]);
            r5_hhy <= (2*HW)'(r4_any[NXW-1:HW]) * (2*HW)'(r4_any[NXW-1:HW]);
            r5_hly <= (2*HW)'(r4_any[NXW-1:HW]) * (2*HW)'(r4_any[HW-1:0]);
            r5_lly <= (2*HW)'(r4_any[HW-1:0]) * (2*HW)'(r4_any[HW-1:0]);

            r6_ctx <= r5_ctx;
            r6_rad <= (w_sqx + w_sqy) << (2 * FRAC);
        end
    end

    assign o_valid       = r_vld[5];
    assign o_data.rad    = r6_rad;
    assign o_data.rem    = '0;
    assign o_data.root   = '0;
    assign o_data.ctx    = r6_ctx;

endmodule

// ----- rtl/ccirc_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// ccirc_sqrt_cell
// One root bit of the integer square root per cell.
// ----------------------------------------------------------------------------
module ccirc_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  ccirc_pkg::t_sq i_data,
    output logic           o_valid,
    output ccirc_pkg::t_sq o_data
);
    import ccirc_pkg::*;

    logic           r_valid;
    t_sq            r_data;
    t_sq            n_data;
    logic [RRW-1:0] w_rem, w_trial;

    always_comb begin
        w_rem   = {i_data.rem[RRW-3:0], i_data.rad[RW-1:RW-2]};
        w_trial = RRW'({i_data.root, 2'b01});
        n_data     = i_data;
        n_data.rad = i_data.rad << 2;
        if (w_rem >= w_trial) begin
            n_data.rem  = w_rem - w_trial;
            n_data.root = {i_data.root[SQW-2:0], 1'b1};
        end else begin
            n_data.rem  = w_rem;
            n_data.root = {i_data.root[SQW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- rtl/ccirc_div_cell.sv -----
// ----------------------------------------------------------------------------
// ccirc_div_cell
// One quotient bit for the x, y and radius lanes per cell.
// ----------------------------------------------------------------------------
module ccirc_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  ccirc_pkg::t_dv i_data,
    output logic           o_valid,
    output ccirc_pkg::t_dv o_data
);
    import ccirc_pkg::*;

    logic r_valid;
    t_dv  r_data;
    t_dv  n_data;
    logic w_bx, w_by, w_br;

    always_comb begin
        w_bx = DSW'(i_data.rem_x) >= i_data.dsh;
        w_by = DSW'(i_data.rem_y) >= i_data.dsh;
        w_br = DSW'(i_data.rem_r) >= i_data.dsh;
        n_data       = i_data;
        n_data.dsh   = i_data.dsh >> 1;
        n_data.q_x   = {i_data.q_x[QW-2:0], w_bx};
        n_data.q_y   = {i_data.q_y[QW-2:0], w_by};
        n_data.q_r   = {i_data.q_r[QW-2:0], w_br};
        n_data.rem_x = w_bx ? NW'(DSW'(i_data.rem_x) - i_data.dsh) : i_data.rem_x;
        n_data.rem_y = w_by ? NW'(DSW'(i_data.rem_y) - i_data.dsh) : i_data.rem_y;
        n_data.rem_r = w_br ? NW'(DSW'(i_data.rem_r) - i_data.dsh) : i_data.rem_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- rtl/circumcircle_from_three_points.sv -----
// ----------------------------------------------------------------------------
// circumcircle_from_three_points
// Centre and radius of the circle through three integer points.
// ----------------------------------------------------------------------------
// One transaction is accepted per cycle and results leave in order through
// 6 product stages, 60 square root cells (one root bit each), 1 setup stage,
// 32 divider cells (one quotient bit each) and the output register. The whole
// pipeline stalls only while the output register holds a result that the sink
// has not taken.
module circumcircle_from_three_points (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // first_x, first_y, second_x, second_y, third_x, third_y
    input  logic [95:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // centre_x, centre_y, circle_radius
    output logic [95:0] o_m_tdata,
    // degenerate, overflowed
    output logic [1:0]  o_m_tuser
);
    import ccirc_pkg::*;

    logic w_en;
    logic w_fv;
    t_sq  w_fd;

    logic [SQW:0] w_sv;
    t_sq          w_sd [SQW+1];

    logic r_pv;
    t_dv  r_pd;

    logic [QW:0] w_dv;
    t_dv         w_dd [QW+1];

    logic        r_out_valid;
    logic [95:0] r_out_data;
    logic [1:0]  r_out_user;

    t_dv           w_last;
    logic          w_ovx, w_ovy;
    logic [QW-1:0] n_cx, n_cy, n_rad;

    assign w_en       = !r_out_valid || i_m_tready;
    assign o_s_tready = w_en;

    ccirc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata[6*CW-1:0]),
        .o_valid (w_fv),
        .o_data  (w_fd)
    );

    assign w_sv[0] = w_fv;
    assign w_sd[0] = w_fd;

    for (genvar g = 0; g < SQW; g++) begin : g_sqrt
        ccirc_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sv[g]),
            .i_data  (w_sd[g]),
            .o_valid (w_sv[g+1]),
            .o_data  (w_sd[g+1])
        );
    end

    // divider setup and range checks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (w_en) begin
            r_pv <= w_sv[SQW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pd.rem_x <= w_sd[SQW].ctx.mag_x;
            r_pd.rem_y <= w_sd[SQW].ctx.mag_y;
            r_pd.rem_r <= NW'(w_sd[SQW].root);
            r_pd.q_x   <= '0;
            r_pd.q_y   <= '0;
            r_pd.q_r   <= '0;
            r_pd.dsh   <= DSW'(w_sd[SQW].ctx.dmag) << (QW - 1);
            r_pd.neg_x <= w_sd[SQW].ctx.neg_x;
            r_pd.neg_y <= w_sd[SQW].ctx.neg_y;
            r_pd.ov_x  <= (DSW+1)'(w_sd[SQW].ctx.mag_x) >= {w_sd[SQW].ctx.dmag, {QW{1'b0}}};
            r_pd.ov_y  <= (DSW+1)'(w_sd[SQW].ctx.mag_y) >= {w_sd[SQW].ctx.dmag, {QW{1'b0}}};
            r_pd.ov_r  <= (DSW+1)'(w_sd[SQW].root) >= {w_sd[SQW].ctx.dmag, {QW{1'b0}}};
            r_pd.deg   <= w_sd[SQW].ctx.deg;
        end
    end

    assign w_dv[0] = r_pv;
    assign w_dd[0] = r_pd;

    for (genvar g = 0; g < QW; g++) begin : g_div
        ccirc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv[g]),
            .i_data  (w_dd[g]),
            .o_valid (w_dv[g+1]),
            .o_data  (w_dd[g+1])
        );
    end

    // saturation and output register
    always_comb begin
        w_last = w_dd[QW];
        w_ovx  = w_last.ov_x || (!w_last.neg_x && w_last.q_x[QW-1]) ||
                 (w_last.neg_x && (w_last.q_x > {1'b1, {(QW-1){1'b0}}}));
        w_ovy  = w_last.ov_y || (!w_last.neg_y && w_last.q_y[QW-1]) ||
                 (w_last.neg_y && (w_last.q_y > {1'b1, {(QW-1){1'b0}}}));
        if (w_ovx) begin
            n_cx = w_last.neg_x ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
        end else begin
            n_cx = w_last.neg_x ? -w_last.q_x : w_last.q_x;
        end
        if (w_ovy) begin
            n_cy = w_last.neg_y ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
        end else begin
            n_cy = w_last.neg_y ? -w_last.q_y : w_last.q_y;
        end
        n_rad = w_last.ov_r ? {QW{1'b1}} : w_last.q_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_last.deg) begin
                r_out_data <= '0;
                r_out_user <= 2'b01;
            end else begin
                r_out_data <= {n_rad, n_cy, n_cx};
                r_out_user <= {w_ovx || w_ovy || w_last.ov_r, 1'b0};
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule
